// ===== rtl/core/iprm_pkg.sv =====
package iprm_pkg;

	// ICMP message types
	localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
	localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

	// result status codes
	localparam logic [2:0] ST_ECHO_MATCH = 3'd0;
	localparam logic [2:0] ST_TE_MATCH   = 3'd1;
	localparam logic [2:0] ST_TOO_SHORT  = 3'd2;
	localparam logic [2:0] ST_OTHER_TYPE = 3'd3;
	localparam logic [2:0] ST_MISMATCH   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_EXPECTED_ID     = 2'd0;
	localparam logic [1:0] CFG_EXPECTED_SEQ    = 2'd1;
	localparam logic [1:0] CFG_PROBE_SEND_TIME = 2'd2;
	localparam logic [1:0] CFG_TARGET_ADDR     = 2'd3;

	// summary queue between parser and result stage
	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		MSG_ECHO,
		MSG_TE,
		MSG_OTHER
	} msg_class_t;

	// per-packet summary built by the parser at the last byte
	typedef struct packed {
		logic        too_short;
		msg_class_t  msg_class;
		logic        fields_seen;
		logic [15:0] id;
		logic [15:0] seq;
		logic [31:0] source;
		logic [31:0] arrival;
	} summary_t;

	typedef struct packed {
		logic [15:0] expected_id;
		logic [15:0] expected_seq;
		logic [31:0] probe_send_time;
		logic [31:0] target_addr;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

// ===== rtl/core/icmp_probe_reply_matcher_top.sv =====
// ICMP probe reply matcher.
// Input channel (in_valid / in_stall): one byte of a received IPv4 packet per
// transaction, end_of_packet marking the last byte; arrival_ms is used on that
// last byte only. Output channel (out_valid / out_stall): one result
// transaction per packet with status, outer source address, round-trip time
// and the reached-target flag.
// Throughput: one byte per cycle while in_stall is low; the byte parser never
// waits on a packet boundary. The summary is written into the queue at the edge
// that accepts the last byte; the result register loads from the queue head once
// the output is free (out_valid low or out_stall low), and out_valid then rises.
// The parser and the result stage are parted by a two-entry summary queue;
// in_stall rises only when that queue is full, i.e. after the receiver has
// held out_stall long enough for two more packets to finish.
// Configuration (cfg_we / cfg_index / cfg_data) is for the user to write only while idle;
// the block does not enforce this. Registers keep their values across packets.
// Reset clears the parser, empties the queue, and clears the output valid and the configuration registers.
module icmp_probe_reply_matcher_top #(
	parameter int MAX_PACKET_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        end_of_packet,
	input  logic [31:0] arrival_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] source_addr,
	output logic [31:0] round_trip_ms,
	output logic        reached_target
);

	iprm_pkg::cfg_t     cfg_q;
	iprm_pkg::summary_t wr_rec;
	iprm_pkg::summary_t rd_rec;
	iprm_pkg::q_stat_t  qstat;
	logic               push;
	logic               pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				iprm_pkg::CFG_EXPECTED_ID:     cfg_q.expected_id     <= cfg_data[15:0];
				iprm_pkg::CFG_EXPECTED_SEQ:    cfg_q.expected_seq    <= cfg_data[15:0];
				iprm_pkg::CFG_PROBE_SEND_TIME: cfg_q.probe_send_time <= cfg_data;
				iprm_pkg::CFG_TARGET_ADDR:     cfg_q.target_addr     <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: byte parser, emits one summary per packet
	iprm_front #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.end_of_packet(end_of_packet),
		.arrival_ms   (arrival_ms),
		.qstat        (qstat),
		.push         (push),
		.rec          (wr_rec)
	);

	iprm_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_rec(wr_rec),
		.pop   (pop),
		.rd_rec(rd_rec),
		.qstat (qstat)
	);

	// back: status decision, RTT, output register
	iprm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (rd_rec),
		.qstat         (qstat),
		.cfg           (cfg_q),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.source_addr   (source_addr),
		.round_trip_ms (round_trip_ms),
		.reached_target(reached_target)
	);

	// a summary is never pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("summary pushed into full queue");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= iprm_pkg::ST_MISMATCH)
		else $error("illegal status code");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != iprm_pkg::ST_ECHO_MATCH && status != iprm_pkg::ST_TE_MATCH)
		|-> (round_trip_ms == 32'd0 && !reached_target))
		else $error("non-match result carries rtt or reached flag");

	a_match_rtt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == iprm_pkg::ST_ECHO_MATCH || status == iprm_pkg::ST_TE_MATCH))
		|-> round_trip_ms != 32'd0)
		else $error("match result with zero rtt");

endmodule

// ===== rtl/core/iprm_front.sv =====
module iprm_front #(
	parameter int MAX_PACKET_BYTES = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               end_of_packet,
	input  logic [31:0]        arrival_ms,
	input  iprm_pkg::q_stat_t  qstat,
	output logic               push,
	output iprm_pkg::summary_t rec
);

	localparam int OFS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam int CW    = (OFS_W > 8) ? OFS_W : 8;
	localparam logic [OFS_W-1:0] MAX_OFS = OFS_W'(MAX_PACKET_BYTES);

	logic [OFS_W-1:0] pos_q, pos_n;
	logic [3:0]       ihl_q, ihl_n;
	logic [3:0]       iihl_q, iihl_n;
	logic [7:0]       type_q, type_n;
	logic [31:0]      src_q, src_n;
	logic [15:0]      id_q, id_n;
	logic [15:0]      seq_q, seq_n;
	logic             fs_q, fs_n;
	logic             accept;

	assign in_stall = qstat.full;
	assign accept   = in_valid && !qstat.full;
	assign push     = accept && end_of_packet;

	always_comb begin
		logic          take;
		logic [CW-1:0] posx;
		logic [CW-1:0] oh;
		logic [CW-1:0] base;
		logic [CW-1:0] k;
		logic          is_echo;
		logic          is_te;
		logic          have_base;

		take    = pos_q < MAX_OFS;
		posx    = CW'(pos_q);
		ihl_n   = (take && pos_q == '0) ? rx_byte[3:0] : ihl_q;
		oh      = CW'({ihl_n, 2'b00});
		src_n   = src_q;
		type_n  = type_q;
		iihl_n  = iihl_q;
		id_n    = id_q;
		seq_n   = seq_q;
		fs_n    = fs_q;
		is_echo = type_q == iprm_pkg::TYPE_ECHO_REPLY;
		is_te   = type_q == iprm_pkg::TYPE_TIME_EXCEEDED;

		if (take && posx >= CW'(12) && posx <= CW'(15)) begin
			case (pos_q[1:0])
				2'd0:    src_n[31:24] = src_q[31:24] | rx_byte;
				2'd1:    src_n[23:16] = src_q[23:16] | rx_byte;
				2'd2:    src_n[15:8]  = src_q[15:8]  | rx_byte;
				default: src_n[7:0]   = src_q[7:0]   | rx_byte;
			endcase
		end

		if (take && posx == oh)
			type_n = rx_byte;

		// the type byte is behind us whenever posx > oh, so type_q is current
		if (take && posx > oh && is_te && posx == oh + CW'(8))
			iihl_n = rx_byte[3:0];

		have_base = take && posx > oh && (is_echo || (is_te && posx > oh + CW'(8)));
		base      = is_echo ? oh : oh + CW'(8) + CW'({iihl_q, 2'b00});
		k         = posx - base;

		if (have_base && k[CW-1:3] == '0 && k[2]) begin
			case (k[1:0])
				2'd0:    id_n[15:8] = rx_byte;
				2'd1:    id_n[7:0]  = rx_byte;
				2'd2:    seq_n[15:8] = rx_byte;
				default: begin
					seq_n[7:0] = rx_byte;
					fs_n       = 1'b1;
				end
			endcase
		end

		pos_n = take ? pos_q + OFS_W'(1) : pos_q;

		rec.too_short = CW'(pos_n) < CW'({ihl_n, 2'b00}) + CW'(8);
		case (type_n)
			iprm_pkg::TYPE_ECHO_REPLY:    rec.msg_class = iprm_pkg::MSG_ECHO;
			iprm_pkg::TYPE_TIME_EXCEEDED: rec.msg_class = iprm_pkg::MSG_TE;
			default:                      rec.msg_class = iprm_pkg::MSG_OTHER;
		endcase
		rec.fields_seen = fs_n;
		rec.id          = id_n;
		rec.seq         = seq_n;
		rec.source      = src_n;
		rec.arrival     = arrival_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ihl_q  <= '0;
			iihl_q <= '0;
			type_q <= '0;
			src_q  <= '0;
			id_q   <= '0;
			seq_q  <= '0;
			fs_q   <= 1'b0;
		end else if (accept) begin
			if (end_of_packet) begin
				pos_q  <= '0;
				ihl_q  <= '0;
				iihl_q <= '0;
				type_q <= '0;
				src_q  <= '0;
				id_q   <= '0;
				seq_q  <= '0;
				fs_q   <= 1'b0;
			end else begin
				pos_q  <= pos_n;
				ihl_q  <= ihl_n;
				iihl_q <= iihl_n;
				type_q <= type_n;
				src_q  <= src_n;
				id_q   <= id_n;
				seq_q  <= seq_n;
				fs_q   <= fs_n;
			end
		end
	end

endmodule

// ===== rtl/core/iprm_queue.sv =====
module iprm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  iprm_pkg::summary_t wr_rec,
	input  logic               pop,
	output iprm_pkg::summary_t rd_rec,
	output iprm_pkg::q_stat_t  qstat
);

	iprm_pkg::summary_t mem_q [iprm_pkg::Q_DEPTH];

	logic [iprm_pkg::Q_AW-1:0] wr_ptr_q;
	logic [iprm_pkg::Q_AW-1:0] rd_ptr_q;
	logic [iprm_pkg::Q_CW-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	localparam logic [iprm_pkg::Q_CW-1:0] DEPTH_C = iprm_pkg::Q_CW'(iprm_pkg::Q_DEPTH);
	localparam logic [iprm_pkg::Q_AW-1:0] LAST_C  = iprm_pkg::Q_AW'(iprm_pkg::Q_DEPTH - 1);

	assign qstat.full     = count_q == DEPTH_C;
	assign qstat.nonempty = count_q != '0;
	assign do_push        = push && !qstat.full;
	assign do_pop         = pop && qstat.nonempty;
	assign rd_rec         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == LAST_C) ? '0 : wr_ptr_q + iprm_pkg::Q_AW'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == LAST_C) ? '0 : rd_ptr_q + iprm_pkg::Q_AW'(1);
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + iprm_pkg::Q_CW'(1);
				2'b01:   count_q <= count_q - iprm_pkg::Q_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/iprm_back.sv =====
module iprm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  iprm_pkg::summary_t head,
	input  iprm_pkg::q_stat_t  qstat,
	input  iprm_pkg::cfg_t     cfg,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [31:0]        source_addr,
	output logic [31:0]        round_trip_ms,
	output logic               reached_target
);

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [31:0] source_q;
	logic [31:0] rtt_q;
	logic        reached_q;
	logic [2:0]  st_c;
	logic [31:0] diff_c;
	logic        match_c;

	assign pop = qstat.nonempty && (!out_valid_q || !out_stall);

	always_comb begin
		if (head.too_short)
			st_c = iprm_pkg::ST_TOO_SHORT;
		else if (head.msg_class == iprm_pkg::MSG_OTHER)
			st_c = iprm_pkg::ST_OTHER_TYPE;
		else if (!head.fields_seen)
			st_c = iprm_pkg::ST_TOO_SHORT;
		else if (head.id != cfg.expected_id || head.seq != cfg.expected_seq)
			st_c = iprm_pkg::ST_MISMATCH;
		else if (head.msg_class == iprm_pkg::MSG_ECHO)
			st_c = iprm_pkg::ST_ECHO_MATCH;
		else
			st_c = iprm_pkg::ST_TE_MATCH;
		match_c = st_c == iprm_pkg::ST_ECHO_MATCH || st_c == iprm_pkg::ST_TE_MATCH;
		diff_c  = head.arrival - cfg.probe_send_time;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			status_q  <= st_c;
			source_q  <= head.source;
			rtt_q     <= !match_c ? 32'd0 : (diff_c == 32'd0) ? 32'd1 : diff_c;
			reached_q <= match_c && head.source == cfg.target_addr;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign source_addr    = source_q;
	assign round_trip_ms  = rtt_q;
	assign reached_target = reached_q;

endmodule
